FILE: rtl/assert_macros.svh
// assertion macros for the thermostat rtl, used by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define DTHS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
// checked on every edge, reset included
`define DTHS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define DTHS_ASSERT(label, clk, rst, prop)
`define DTHS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: rtl/dths_pkg.sv
// types, constants and command struct for the dual thermostat
package dths_pkg;

  typedef struct packed {
    logic signed [11:0] temp_a;
    logic               temp_a_ok;
    logic [9:0]         pot_a;
    logic               pot_a_ok;
    logic signed [11:0] temp_b;
    logic               temp_b_ok;
    logic [9:0]         pot_b;
    logic               pot_b_ok;
  } in_item_t;

  typedef struct packed {
    logic       send_frame;
    logic       frame_kind;
    logic       out_a;
    logic       out_b;
    logic [8:0] setpoint_a;
    logic [8:0] setpoint_b;
  } out_item_t;

  // control register indexes
  localparam logic [1:0] CFG_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_SUMMER     = 2'd1;
  localparam logic [1:0] CFG_HYSTERESIS = 2'd2;

  localparam logic       ENABLE_RESET     = 1'b0;
  localparam logic       SUMMER_RESET     = 1'b1;
  localparam logic [7:0] HYSTERESIS_RESET = 8'd16;

  localparam logic [9:0] READ_CLAMP = 10'd950;
  localparam logic [9:0] BAND_LOW   = 10'd180;
  localparam logic [9:0] BAND_HIGH  = 10'd205;

  // quadratic coefficients, scaled by 2^20
  localparam logic signed [24:0] LOW_C2  = -25'sd11325;
  localparam logic signed [24:0] LOW_C1  = 25'sd4860779;
  localparam logic signed [35:0] LOW_C0  = -36'sd373324513;
  localparam logic signed [24:0] HIGH_C2 = -25'sd210;
  localparam logic signed [24:0] HIGH_C1 = 25'sd469972;
  localparam logic signed [35:0] HIGH_C0 = 36'sd69981962;

  // angle in 1/256 degree
  localparam logic [16:0] ANGLE_MID = 17'd34560;
  localparam logic [16:0] ANGLE_MAX = 17'd69120;

  // angle / 216 = (angle >> 3) / 27, and x / 27 = (x * 9710) >> 18 for x below 8641
  localparam logic signed [14:0] DIV27_MUL   = 15'sd9710;
  localparam int                 DIV27_SHIFT = 18;
  localparam logic [8:0]         SP_BASE     = 9'd160;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic angle;
    logic div;
    logic update;
    logic emit;
    logic zone;
  } dp_cmd_t;

endpackage

FILE: rtl/dths_dp.sv
// datapath: shared multiplier, setpoint mapping, hysteresis and zone bits
module dths_dp (
  input  logic                clk,
  input  logic                rst,
  input  dths_pkg::dp_cmd_t   cmd,
  input  dths_pkg::in_item_t  in_data,
  input  logic                enable,
  input  logic                summer_mode,
  input  logic [7:0]          hysteresis,
  output dths_pkg::out_item_t out_data
);

  dths_pkg::in_item_t  item;
  dths_pkg::out_item_t result;
  logic signed [39:0]  prod;
  logic [13:0]         xq;
  logic [1:0]          zone_on;
  logic [8:0]          sp [2];
  logic                changed;

  logic signed [11:0]  temp_sel;
  logic                tok_sel;
  logic [9:0]          pot_sel;
  logic                pok_sel;
  logic [9:0]          r;
  logic                band_lo;
  logic                band_mid;
  logic signed [24:0]  mul_a;
  logic signed [14:0]  mul_b;
  logic signed [39:0]  mul_p;
  logic signed [35:0]  acc;
  logic [16:0]         angle;
  logic [8:0]          sp_val;
  logic signed [13:0]  d;
  logic signed [13:0]  h;
  logic                set_on;
  logic                clr_on;

  always_comb begin
    temp_sel = cmd.zone ? item.temp_b : item.temp_a;
    tok_sel  = cmd.zone ? item.temp_b_ok : item.temp_a_ok;
    pot_sel  = cmd.zone ? item.pot_b : item.pot_a;
    pok_sel  = cmd.zone ? item.pot_b_ok : item.pot_a_ok;
    r        = (pot_sel > dths_pkg::READ_CLAMP) ? dths_pkg::READ_CLAMP : pot_sel;
    band_lo  = r < dths_pkg::BAND_LOW;
    band_mid = !band_lo && (r <= dths_pkg::BAND_HIGH);
  end

  // one multiplier, shared by both horner steps and the divide by 27
  always_comb begin
    mul_b = $signed({5'b0, r});
    if (cmd.div) begin
      mul_a = $signed({11'b0, xq});
      mul_b = dths_pkg::DIV27_MUL;
    end else if (cmd.mul2) begin
      mul_a = prod[24:0] + (band_lo ? dths_pkg::LOW_C1 : dths_pkg::HIGH_C1);
    end else begin
      mul_a = band_lo ? dths_pkg::LOW_C2 : dths_pkg::HIGH_C2;
    end
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    acc = prod[35:0] + (band_lo ? dths_pkg::LOW_C0 : dths_pkg::HIGH_C0);
    if (band_mid) begin
      angle = dths_pkg::ANGLE_MID;
    end else if (acc[35]) begin
      angle = '0;
    end else if (acc[35:12] > {7'b0, dths_pkg::ANGLE_MAX}) begin
      angle = dths_pkg::ANGLE_MAX;
    end else begin
      angle = acc[28:12];
    end
  end

  always_comb begin
    sp_val = pok_sel ? (dths_pkg::SP_BASE
                        + prod[dths_pkg::DIV27_SHIFT+8:dths_pkg::DIV27_SHIFT]) : '0;
    h      = $signed({6'b0, hysteresis});
    if (summer_mode) begin
      d = 14'(temp_sel) - $signed({5'b0, sp_val});
    end else begin
      d = $signed({5'b0, sp_val}) - 14'(temp_sel);
    end
    set_on = enable && tok_sel && pok_sel && (d > h);
    clr_on = enable && tok_sel && pok_sel && (d < -h);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.mul1 || cmd.mul2 || cmd.div) begin
      prod <= mul_p;
    end
    if (cmd.angle) begin
      xq <= angle[16:3];
    end
    if (cmd.update) begin
      sp[cmd.zone] <= sp_val;
    end
    if (cmd.emit) begin
      result.send_frame <= enable ? changed : 1'b1;
      result.frame_kind <= !enable;
      result.out_a      <= zone_on[0];
      result.out_b      <= zone_on[1];
      result.setpoint_a <= sp[0];
      result.setpoint_b <= sp[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_on <= '0;
      changed <= 1'b0;
    end else begin
      if (cmd.load) begin
        changed <= 1'b0;
      end else if (cmd.update) begin
        if (set_on && !zone_on[cmd.zone]) begin
          zone_on[cmd.zone] <= 1'b1;
          changed           <= 1'b1;
        end else if (clr_on && zone_on[cmd.zone]) begin
          zone_on[cmd.zone] <= 1'b0;
          changed           <= 1'b1;
        end
      end
    end
  end

  assign out_data = result;

endmodule

FILE: rtl/dths_ctrl.sv
// controller: sequences both zones through the shared datapath
`include "assert_macros.svh"

module dths_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dths_pkg::dp_cmd_t cmd
);

  typedef enum logic [6:0] {
    IDLE   = 7'b0000001,
    MUL1   = 7'b0000010,
    MUL2   = 7'b0000100,
    ANGLE  = 7'b0001000,
    DIV    = 7'b0010000,
    UPDATE = 7'b0100000,
    DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   zone;
  logic   emit;

  assign in_ready = (state == IDLE);
  assign emit     = (state == DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      IDLE:    if (in_valid) state_next = MUL1;
      MUL1:    state_next = MUL2;
      MUL2:    state_next = ANGLE;
      ANGLE:   state_next = DIV;
      DIV:     state_next = UPDATE;
      UPDATE:  state_next = zone ? DONE : MUL1;
      DONE:    if (emit) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      zone      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == IDLE) begin
        zone <= 1'b0;
      end else if (state == UPDATE) begin
        zone <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd.load   = in_valid && in_ready;
    cmd.mul1   = (state == MUL1);
    cmd.mul2   = (state == MUL2);
    cmd.angle  = (state == ANGLE);
    cmd.div    = (state == DIV);
    cmd.update = (state == UPDATE);
    cmd.emit   = emit;
    cmd.zone   = zone;
  end

  // a transfer in starts zone A
  `DTHS_ASSERT(a_start, clk, rst, (in_valid && in_ready) |=> (state == MUL1 && !zone))
  // zone A hands over to zone B, zone B finishes the item
  `DTHS_ASSERT(a_zone_seq, clk, rst, (state == UPDATE && !zone) |=> (state == MUL1 && zone))
  // a loaded result is offered on the next cycle
  `DTHS_ASSERT(a_emit, clk, rst, emit |=> (out_valid && state == IDLE))
  // reset returns the controller to idle with no result offered
  `DTHS_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> (state == IDLE && !out_valid))

endmodule

FILE: rtl/dual_thermostat_hysteresis_setpoint.sv
// Dual-zone thermostat with pot-derived setpoints and hysteresis.
// Sequence: zone A, then zone B, then the result register once it is free;
// no new item is taken until then. Each zone takes five steps (two horner
// steps, angle, divide by 27, update); three use the single shared multiplier.
// Result register: the next item is taken while a result waits on the output.
// Reset (rst, synchronous): zone bits off, enable 0, summer mode 1, hysteresis 16.
module dual_thermostat_hysteresis_setpoint (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dths_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dths_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  dths_pkg::dp_cmd_t cmd;
  logic              enable;
  logic              summer_mode;
  logic [7:0]        hysteresis;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= dths_pkg::ENABLE_RESET;
      summer_mode <= dths_pkg::SUMMER_RESET;
      hysteresis  <= dths_pkg::HYSTERESIS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dths_pkg::CFG_ENABLE:     enable      <= cfg_data[0];
        dths_pkg::CFG_SUMMER:     summer_mode <= cfg_data[0];
        dths_pkg::CFG_HYSTERESIS: hysteresis  <= cfg_data;
        default: ;
      endcase
    end
  end

  dths_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dths_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_data     (in_data),
    .enable      (enable),
    .summer_mode (summer_mode),
    .hysteresis  (hysteresis),
    .out_data    (out_data)
  );

endmodule

FILE: bench/dual_thermostat_hysteresis_setpoint_test.sv
// self-checking testbench for the dual-zone thermostat with setpoint knobs
module dual_thermostat_hysteresis_setpoint_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 120;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_IDLE     = 12;
  localparam int MAX_REPORTS  = 40;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // knob curve, coefficients scaled by 2^20
  localparam longint LO_A2    = -64'sd11325;
  localparam longint LO_A1    = 64'sd4860779;
  localparam longint LO_A0    = -64'sd373324513;
  localparam longint HI_A2    = -64'sd210;
  localparam longint HI_A1    = 64'sd469972;
  localparam longint HI_A0    = 64'sd69981962;
  localparam longint POT_MAX  = 64'sd950;
  localparam longint BAND_LO  = 64'sd180;
  localparam longint BAND_HI  = 64'sd205;
  localparam longint ANG_MID  = 64'sd34560;
  localparam longint ANG_SAT  = 64'sd69120;
  localparam longint SP_FLOOR = 64'sd160;
  localparam longint SP_STEP  = 64'sd216;

  typedef struct {
    bit                  en;
    bit                  sm;
    logic [7:0]          hy;
    dths_pkg::in_item_t  item;
    bit                  known;
    dths_pkg::out_item_t want;
  } dir_row_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  dths_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dths_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [7:0]          cfg_data  = '0;

  // mirror of the block state and registers
  bit         heat_on [2];
  bit         run_en    = 1'b0;
  bit         cool_mode = 1'b1;
  logic [7:0] band      = 8'd16;

  dths_pkg::out_item_t pending_results [$];
  dir_row_t            rows [$];
  bit                  quiet  = 1'b0;
  int                  errors = 0;
  int unsigned         cycles = 0;

  dual_thermostat_hysteresis_setpoint u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [8:0] pot_setpoint(logic [9:0] pot);
    longint r;
    longint a;
    longint ang;
    r = longint'(pot);
    if (r > POT_MAX) r = POT_MAX;
    if (r >= BAND_LO && r <= BAND_HI) begin
      ang = ANG_MID;
    end else begin
      if (r < BAND_LO) a = LO_A2 * r * r + LO_A1 * r + LO_A0;
      else a = HI_A2 * r * r + HI_A1 * r + HI_A0;
      if (a < 0) ang = 0;
      else ang = ((a >>> 12) > ANG_SAT) ? ANG_SAT : (a >>> 12);
    end
    return 9'(SP_FLOOR + ang / SP_STEP);
  endfunction

  // advances the zone bits and returns the frame request for one reading
  function automatic dths_pkg::out_item_t predict_frame(dths_pkg::in_item_t it);
    logic signed [11:0]  t [2];
    logic [9:0]          p [2];
    bit                  tok [2];
    bit                  pok [2];
    logic [8:0]          sp [2];
    bit                  changed;
    int                  d;
    int                  h;
    int                  z;
    dths_pkg::out_item_t r;
    t[0] = it.temp_a;  tok[0] = it.temp_a_ok;  p[0] = it.pot_a;  pok[0] = it.pot_a_ok;
    t[1] = it.temp_b;  tok[1] = it.temp_b_ok;  p[1] = it.pot_b;  pok[1] = it.pot_b_ok;
    changed = 1'b0;
    h = int'(band);
    for (z = 0; z < 2; z++) begin
      sp[z] = pok[z] ? pot_setpoint(p[z]) : 9'd0;
      if (run_en && tok[z] && pok[z]) begin
        d = cool_mode ? int'(t[z]) - int'(sp[z]) : int'(sp[z]) - int'(t[z]);
        if (d > h && !heat_on[z]) begin
          heat_on[z] = 1'b1;
          changed = 1'b1;
        end else if (d < -h && heat_on[z]) begin
          heat_on[z] = 1'b0;
          changed = 1'b1;
        end
      end
    end
    r.send_frame = run_en ? changed : 1'b1;
    r.frame_kind = !run_en;
    r.out_a      = heat_on[0];
    r.out_b      = heat_on[1];
    r.setpoint_a = sp[0];
    r.setpoint_b = sp[1];
    return r;
  endfunction

  function automatic dths_pkg::in_item_t zin(int ta, bit tao, int pa, bit pao,
                                             int tb, bit tbo, int pb, bit pbo);
    dths_pkg::in_item_t it;
    it.temp_a = 12'(ta);  it.temp_a_ok = tao;  it.pot_a = 10'(pa);  it.pot_a_ok = pao;
    it.temp_b = 12'(tb);  it.temp_b_ok = tbo;  it.pot_b = 10'(pb);  it.pot_b_ok = pbo;
    return it;
  endfunction

  function automatic dths_pkg::out_item_t zout(bit sf, bit fk, bit oa, bit ob,
                                               int spa, int spb);
    dths_pkg::out_item_t r;
    r.send_frame = sf;
    r.frame_kind = fk;
    r.out_a      = oa;
    r.out_b      = ob;
    r.setpoint_a = 9'(spa);
    r.setpoint_b = 9'(spb);
    return r;
  endfunction

  function automatic dir_row_t row(bit en, bit sm, logic [7:0] hy, dths_pkg::in_item_t it,
                                   bit known, dths_pkg::out_item_t want);
    dir_row_t r;
    r.en = en;  r.sm = sm;  r.hy = hy;
    r.item = it;  r.known = known;  r.want = want;
    return r;
  endfunction

  // mostly temperatures near the setpoint so the zones keep switching
  function automatic dths_pkg::in_item_t rand_item(bit noise);
    logic [9:0]         p [2];
    logic signed [11:0] t [2];
    bit                 tok [2];
    bit                 pok [2];
    int                 spread;
    int                 offs;
    int                 z;
    dths_pkg::in_item_t it;
    if (noise) return dths_pkg::in_item_t'(48'({$urandom, $urandom}));
    spread = int'(band) + 40;
    for (z = 0; z < 2; z++) begin
      case ($urandom_range(0, 9))
        0, 1:    p[z] = 10'($urandom_range(150, 235));
        2:       p[z] = 10'($urandom_range(930, 1023));
        default: p[z] = 10'($urandom_range(0, 1023));
      endcase
      pok[z] = $urandom_range(0, 15) != 0;
      tok[z] = $urandom_range(0, 15) != 0;
      offs = int'($urandom_range(0, 2 * spread)) - spread;
      if ($urandom_range(0, 3) != 0) t[z] = 12'(int'(pot_setpoint(p[z])) + offs);
      else t[z] = 12'($urandom);
    end
    it.temp_a = t[0];  it.temp_a_ok = tok[0];  it.pot_a = p[0];  it.pot_a_ok = pok[0];
    it.temp_b = t[1];  it.temp_b_ok = tok[1];  it.pot_b = p[1];  it.pot_b_ok = pok[1];
    return it;
  endfunction

  task automatic send_item(dths_pkg::in_item_t it, bit known, dths_pkg::out_item_t want);
    int gap;
    dths_pkg::out_item_t predicted;
    gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_frame(it);
    pending_results.push_back(known ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      dths_pkg::CFG_ENABLE:     run_en = val[0];
      dths_pkg::CFG_SUMMER:     cool_mode = val[0];
      dths_pkg::CFG_HYSTERESIS: band = val;
      default: ;
    endcase
  endtask

  // only the low bit of the mode registers counts, so the rest is random
  task automatic apply_cfg(bit en, bit sm, logic [7:0] hy);
    drain_results();
    cfg_write(CFG_UNUSED, 8'($urandom));
    cfg_write(dths_pkg::CFG_ENABLE, {7'($urandom), en});
    cfg_write(dths_pkg::CFG_SUMMER, {7'($urandom), sm});
    cfg_write(dths_pkg::CFG_HYSTERESIS, hy);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    dths_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t unexpected result: expected none actual %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("send_frame", 9'(want.send_frame), 9'(out_data.send_frame));
        check_field("frame_kind", 9'(want.frame_kind), 9'(out_data.frame_kind));
        check_field("out_a", 9'(want.out_a), 9'(out_data.out_a));
        check_field("out_b", 9'(want.out_b), 9'(out_data.out_b));
        check_field("setpoint_a", want.setpoint_a, out_data.setpoint_a);
        check_field("setpoint_b", want.setpoint_b, out_data.setpoint_b);
      end
    end
  end

  initial begin
    int         i;
    int         p;
    bit         en;
    bit         sm;
    logic [7:0] hy;

    heat_on[0] = 1'b0;
    heat_on[1] = 1'b0;

    // disabled after reset: disable frame, setpoint extremes, band plateau, bad knobs
    rows.push_back(row(0, 1, 16, zin(2047, 1, 0, 1, -2048, 1, 1023, 1), 1,
                       zout(1, 1, 0, 0, 160, 480)));
    rows.push_back(row(0, 1, 16, zin(0, 1, 180, 1, 0, 1, 205, 1), 1,
                       zout(1, 1, 0, 0, 320, 320)));
    rows.push_back(row(0, 1, 16, zin(100, 1, 1023, 0, -1, 0, 512, 0), 1,
                       zout(1, 1, 0, 0, 0, 0)));
    // cooling: switch on, hold, sit on the band edges, switch off
    rows.push_back(row(1, 1, 16, zin(2047, 1, 192, 1, 2047, 1, 192, 1), 1,
                       zout(1, 0, 1, 1, 320, 320)));
    rows.push_back(row(1, 1, 16, zin(2047, 1, 192, 1, 2047, 1, 192, 1), 1,
                       zout(0, 0, 1, 1, 320, 320)));
    rows.push_back(row(1, 1, 16, zin(336, 1, 192, 1, 304, 1, 192, 1), 1,
                       zout(0, 0, 1, 1, 320, 320)));
    rows.push_back(row(1, 1, 16, zin(337, 1, 192, 1, 303, 1, 192, 1), 0, '0));
    rows.push_back(row(1, 1, 16, zin(-2048, 1, 192, 1, -2048, 1, 192, 1), 0, '0));
    // bad sensor on one zone, bad knob on the other; then band edges, clamp and knob ends
    rows.push_back(row(1, 1, 16, zin(2047, 0, 192, 1, 2047, 1, 192, 0), 1,
                       zout(0, 0, 0, 0, 320, 0)));
    rows.push_back(row(1, 1, 16, zin(400, 1, 179, 1, 400, 1, 206, 1), 0, '0));
    rows.push_back(row(1, 1, 16, zin(0, 1, 950, 1, 0, 1, 951, 1), 1,
                       zout(1, 0, 0, 0, 480, 480)));
    rows.push_back(row(1, 1, 16, zin(-1, 1, 1, 1, 2047, 1, 1022, 1), 0, '0));
    // heating with no band
    rows.push_back(row(1, 0, 0, zin(0, 1, 1023, 1, 0, 1, 1023, 1), 1,
                       zout(1, 0, 1, 1, 480, 480)));
    rows.push_back(row(1, 0, 0, zin(480, 1, 1023, 1, 481, 1, 1023, 1), 0, '0));
    rows.push_back(row(1, 0, 0, zin(300, 1, 100, 1, 500, 1, 600, 1), 0, '0));
    rows.push_back(row(1, 0, 0, zin(-2048, 1, 512, 1, 2047, 1, 300, 1), 0, '0));
    // widest band
    rows.push_back(row(1, 1, 255, zin(575, 1, 192, 1, 576, 1, 192, 1), 0, '0));
    rows.push_back(row(1, 1, 255, zin(64, 1, 192, 1, 2047, 1, 700, 1), 0, '0));
    rows.push_back(row(1, 1, 255, zin(-2048, 1, 192, 1, -300, 1, 850, 1), 0, '0));
    // disabled while zones are on: bits frozen; then enabled again
    rows.push_back(row(0, 0, 255, zin(-2048, 1, 192, 1, 2047, 1, 192, 1), 0, '0));
    rows.push_back(row(0, 0, 255, zin(2047, 1, 800, 1, -2048, 1, 40, 0), 0, '0));
    rows.push_back(row(1, 0, 128, zin(1000, 1, 190, 1, -500, 1, 1000, 1), 0, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < rows.size(); i++) begin
      if (rows[i].en != run_en || rows[i].sm != cool_mode || rows[i].hy != band)
        apply_cfg(rows[i].en, rows[i].sm, rows[i].hy);
      send_item(rows[i].item, rows[i].known, rows[i].want);
    end

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin en = 1'b1; sm = 1'b1; hy = 8'd0;   end
        1: begin en = 1'b1; sm = 1'b0; hy = 8'd255; end
        2: begin en = 1'b0; sm = 1'b1; hy = 8'($urandom); end
        3: begin en = 1'b1; sm = 1'b0; hy = 8'd0;   end
        4: begin en = 1'b1; sm = 1'b1; hy = 8'd255; end
        default: begin
          en = $urandom_range(0, 5) != 0;
          sm = 1'($urandom_range(0, 1));
          hy = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 32)) : 8'($urandom);
        end
      endcase
      apply_cfg(en, sm, hy);
      // every fourth phase runs back to back on both sides
      quiet = (p % 4 == 2);
      for (i = 0; i < PHASE_ITEMS; i++)
        send_item(rand_item($urandom_range(0, 9) == 0), 1'b0, '0);
    end

    quiet = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/dths_pkg.sv
rtl/dths_dp.sv
rtl/dths_ctrl.sv
rtl/dual_thermostat_hysteresis_setpoint.sv
bench/dual_thermostat_hysteresis_setpoint_test.sv
